// ===== design/object_dictionary_access_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef OBJECT_DICTIONARY_ACCESS_MACROS_SVH
`define OBJECT_DICTIONARY_ACCESS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ODA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ODA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/oda_pkg.sv =====
`timescale 1ns / 1ps

package oda_pkg;

    localparam int ODA_NUM_OBJECTS = 9;
    localparam int ODA_NUM_ENTRIES = 18;

    typedef enum logic [1:0] {
        ACC_RW    = 2'd0,
        ACC_WO    = 2'd1,
        ACC_RO    = 2'd2,
        ACC_CONST = 2'd3
    } oda_access_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_INDEX = 3'd1,
        ST_NO_SUB   = 3'd2,
        ST_DENIED   = 3'd3,
        ST_SIZE     = 3'd4
    } oda_status_t;

    typedef struct packed {
        logic        action;
        logic [15:0] object_index;
        logic [7:0]  sub_index;
        logic [4:0]  byte_count;
        logic [31:0] write_value;
    } oda_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
    } oda_rsp_t;

    // One object slot of the dictionary.
    typedef struct packed {
        logic        valid;
        logic [15:0] index;
        logic [7:0]  first;
        logic [7:0]  count;
    } oda_slot_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic       valid;
        logic       found;
        logic [7:0] first;
        logic [7:0] count;
    } oda_token_t;

    // Entry descriptor; size 0 means no supported size.
    typedef struct packed {
        logic        valid;
        oda_access_t access;
        logic [2:0]  size;
        logic [31:0] init;
    } oda_desc_t;

    function automatic oda_slot_t obj_rom(input int slot);
        oda_slot_t s;
        s = '0;
        case (slot)
            0:       s = '{1'b1, 16'h1000, 8'd0,  8'd1};
            1:       s = '{1'b1, 16'h1001, 8'd1,  8'd1};
            2:       s = '{1'b1, 16'h1008, 8'd2,  8'd1};
            3:       s = '{1'b1, 16'h1016, 8'd3,  8'd2};
            4:       s = '{1'b1, 16'h1017, 8'd5,  8'd1};
            5:       s = '{1'b1, 16'h1018, 8'd6,  8'd5};
            6:       s = '{1'b1, 16'h1F80, 8'd11, 8'd1};
            7:       s = '{1'b1, 16'h1F51, 8'd12, 8'd6};
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic oda_desc_t entry_rom(input int entry);
        oda_desc_t d;
        d = '0;
        case (entry)
            0:       d = '{1'b1, ACC_RO,    3'd4, 32'd0};
            1:       d = '{1'b1, ACC_RO,    3'd1, 32'd0};
            2:       d = '{1'b1, ACC_CONST, 3'd0, 32'd0};  // string entry, no size
            3:       d = '{1'b1, ACC_CONST, 3'd1, 32'd1};
            4:       d = '{1'b1, ACC_RW,    3'd4, 32'd0};
            5:       d = '{1'b1, ACC_RW,    3'd2, 32'd0};
            6:       d = '{1'b1, ACC_CONST, 3'd1, 32'd4};
            7:       d = '{1'b1, ACC_RO,    3'd4, 32'd0};
            8:       d = '{1'b1, ACC_RO,    3'd4, 32'd0};
            9:       d = '{1'b1, ACC_RO,    3'd4, 32'd0};
            10:      d = '{1'b1, ACC_RO,    3'd4, 32'd0};
            11:      d = '{1'b1, ACC_RW,    3'd4, 32'd0};
            12:      d = '{1'b1, ACC_RO,    3'd1, 32'd0};
            13:      d = '{1'b1, ACC_WO,    3'd4, 32'd0};
            14:      d = '{1'b1, ACC_WO,    3'd4, 32'd0};
            15:      d = '{1'b1, ACC_WO,    3'd4, 32'd0};
            16:      d = '{1'b1, ACC_WO,    3'd4, 32'd0};
            17:      d = '{1'b1, ACC_WO,    3'd4, 32'd0};
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] entry_init(input int entry);
        oda_desc_t d;
        d = entry_rom(entry);
        return d.init;
    endfunction

    function automatic logic [31:0] size_mask(input logic [2:0] size);
        logic [31:0] m;
        case (size)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd4:    m = 32'hFFFF_FFFF;
            default: m = 32'h0000_0000;
        endcase
        return m;
    endfunction

endpackage

// ===== design/oda_cell.sv =====
`timescale 1ns / 1ps

module oda_cell #(
    parameter int SLOT_ID = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         object_index,
    input  oda_pkg::oda_token_t tok_in,
    output oda_pkg::oda_token_t tok_out
);
    import oda_pkg::*;

    localparam oda_slot_t Slot = obj_rom(SLOT_ID);

    oda_token_t tok_reg;
    oda_token_t tok_next;
    logic       hit;

    // First matching slot wins; later cells leave the token alone.
    assign hit = tok_in.valid && !tok_in.found && Slot.valid
                 && (Slot.index == object_index);

    always_comb begin
        tok_next = tok_in;
        if (hit) begin
            tok_next.found = 1'b1;
            tok_next.first = Slot.first;
            tok_next.count = Slot.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/oda_entry.sv =====
`timescale 1ns / 1ps

module oda_entry #(
    parameter int NUM_ENTRIES = oda_pkg::ODA_NUM_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                eval_en,
    input  oda_pkg::oda_req_t   req,
    input  oda_pkg::oda_token_t tok,
    output oda_pkg::oda_rsp_t   rsp
);
    import oda_pkg::*;

    localparam int IdxW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    logic [31:0]     data_reg [NUM_ENTRIES];
    logic [8:0]      entry_sum;
    logic            in_range;
    logic [IdxW-1:0] idx;
    oda_desc_t       desc;
    logic            denied;
    oda_status_t     status;
    logic            write_en;

    assign entry_sum = {1'b0, tok.first} + {1'b0, req.sub_index};
    assign in_range  = entry_sum < 9'(NUM_ENTRIES);
    assign idx       = entry_sum[IdxW-1:0];
    assign desc      = entry_rom(int'(idx));

    assign denied = ((desc.access == ACC_WO) && !req.action)
                 || (((desc.access == ACC_RO) || (desc.access == ACC_CONST)) && req.action);

    always_comb begin
        if (!tok.found) begin
            status = ST_NO_INDEX;
        end else if ((req.sub_index >= tok.count) || !in_range || !desc.valid) begin
            status = ST_NO_SUB;
        end else if (denied) begin
            status = ST_DENIED;
        end else if ((desc.size == 3'd0) || ({2'b00, desc.size} != req.byte_count)) begin
            status = ST_SIZE;
        end else begin
            status = ST_OK;
        end
    end

    assign write_en = eval_en && (status == ST_OK) && req.action;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                data_reg[i] <= entry_init(i);
            end
        end else if (write_en) begin
            data_reg[idx] <= req.write_value & size_mask(desc.size);
        end
    end

    always_comb begin
        rsp.status     = status;
        rsp.read_value = ((status == ST_OK) && !req.action)
                       ? (data_reg[idx] & size_mask(desc.size)) : 32'd0;
    end

endmodule

// ===== design/object_dictionary_access.sv =====
`timescale 1ns / 1ps

// Channel    Ports                          Carries
// request    s_valid s_ready s_request      action, index, subindex, byte count, data
// result     m_valid m_ready m_result       status, read data
//
// One request at a time: launch_reg starts a token that walks the row of object
// cells, one cell a cycle, into pend_reg, which waits for the result register.
// A new request is taken in the cycle after its predecessor's result is loaded,
// even while that result still waits on m_ready.
// Reset reloads the entry data defaults; the object table is a constant ROM.

module object_dictionary_access #(
    parameter int NUM_OBJECTS = oda_pkg::ODA_NUM_OBJECTS,
    parameter int NUM_ENTRIES = oda_pkg::ODA_NUM_ENTRIES
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  oda_pkg::oda_req_t s_request,
    output logic              m_valid,
    input  logic              m_ready,
    output oda_pkg::oda_rsp_t m_result
);
    import oda_pkg::*;

    oda_req_t   req_reg;
    logic       busy_reg,   busy_next;
    logic       launch_reg;
    oda_token_t pend_reg;
    logic       m_valid_reg, m_valid_next;
    oda_rsp_t   rsp_reg;
    oda_rsp_t   eval_rsp;
    oda_token_t tok_chain [NUM_OBJECTS+1];
    logic       accept;
    logic       eval_fire;

    assign accept    = s_valid && s_ready;
    assign eval_fire = pend_reg.valid && (!m_valid_reg || m_ready);

    assign tok_chain[0] = '{valid: launch_reg, found: 1'b0, first: 8'd0, count: 8'd0};

    for (genvar k = 0; k < NUM_OBJECTS; k++) begin : g_cell
        oda_cell #(
            .SLOT_ID (k)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .object_index (req_reg.object_index),
            .tok_in       (tok_chain[k]),
            .tok_out      (tok_chain[k+1])
        );
    end

    oda_entry #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_entry (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eval_en (eval_fire),
        .req     (req_reg),
        .tok     (pend_reg),
        .rsp     (eval_rsp)
    );

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (eval_fire) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (eval_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            launch_reg     <= 1'b0;
            pend_reg.valid <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            launch_reg  <= accept;
            m_valid_reg <= m_valid_next;
            // hold the search outcome until the result register frees up
            if (tok_chain[NUM_OBJECTS].valid) begin
                pend_reg <= tok_chain[NUM_OBJECTS];
            end else if (eval_fire) begin
                pend_reg.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_request;
        end
        if (eval_fire) begin
            rsp_reg <= eval_rsp;
        end
    end

    assign s_ready  = !busy_reg;
    assign m_valid  = m_valid_reg;
    assign m_result = rsp_reg;

endmodule

// ===== design/oda_checker.sv =====
`timescale 1ns / 1ps

`include "object_dictionary_access_macros.svh"

module oda_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input oda_pkg::oda_req_t s_request,
    input logic              m_valid,
    input logic              m_ready,
    input oda_pkg::oda_rsp_t m_result
);
    import oda_pkg::*;

    logic s_fire;
    logic s_stall;
    logic m_stall;
    logic failed;
    logic rd_zero;

    assign s_fire  = s_valid && s_ready;
    assign s_stall = s_valid && !s_ready;
    assign m_stall = m_valid && !m_ready;
    assign failed  = m_result.status != ST_OK;
    assign rd_zero = m_result.read_value == 32'd0;

    `ODA_ASSERT_NEXT(a_result_held, m_stall, m_valid && $stable(m_result), "result moved")
    `ODA_ASSERT_NEXT(a_one_in_flight, s_fire, !s_ready, "second request taken while busy")
    `ODA_ASSERT_NOW(a_fail_reads_zero, m_valid && failed, rd_zero, "failed request with data")
    `ODA_ASSERT_NOW(a_result_ends_request, $rose(m_valid), $past(!s_ready), "orphan result")
    `ODA_ASSERT_NEXT(a_request_held, s_stall, s_valid && $stable(s_request), "request moved")

endmodule

bind object_dictionary_access oda_checker u_oda_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_request (s_request),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_result  (m_result)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import oda_pkg::*;

    localparam int MAX_CYCLES   = 300000;
    localparam int OBJECT_ROWS  = 8;
    localparam int ENTRY_ROWS   = 18;
    localparam int RANDOM_COUNT = 700;
    localparam int DRAIN_WAIT   = 30;

    typedef struct {
        oda_req_t req;
        int       gap;
        bit       drain;
    } req_item_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    oda_req_t s_request = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    oda_rsp_t m_result;

    req_item_t   pending_requests[$];
    oda_rsp_t    expected_results[$];
    logic        req_fire = 1'b0;
    logic        rsp_fire = 1'b0;
    int unsigned rsp_count = 0;
    int unsigned queued_count = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int          gap_left = -1;
    int          hold_left = 0;

    // Dictionary mirror: object rows and entry rows.
    logic [15:0] obj_index_tab[OBJECT_ROWS];
    int          obj_len[OBJECT_ROWS];
    int          obj_base[OBJECT_ROWS];
    oda_access_t entry_acc[ENTRY_ROWS];
    int          entry_bytes[ENTRY_ROWS];
    logic [31:0] entry_word[ENTRY_ROWS];

    object_dictionary_access u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_request(s_request),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic load_dictionary();
        int base;
        obj_index_tab = '{16'h1000, 16'h1001, 16'h1008, 16'h1016,
                          16'h1017, 16'h1018, 16'h1F80, 16'h1F51};
        obj_len       = '{1, 1, 1, 2, 1, 5, 1, 6};
        entry_acc     = '{ACC_RO, ACC_RO, ACC_CONST, ACC_CONST, ACC_RW, ACC_RW,
                          ACC_CONST, ACC_RO, ACC_RO, ACC_RO, ACC_RO, ACC_RW,
                          ACC_RO, ACC_WO, ACC_WO, ACC_WO, ACC_WO, ACC_WO};
        // String entry has no usable size, so it is 0 here.
        entry_bytes   = '{4, 1, 0, 1, 4, 2, 1, 4, 4, 4, 4, 4, 1, 4, 4, 4, 4, 4};
        base = 0;
        for (int i = 0; i < OBJECT_ROWS; i++) begin
            obj_base[i] = base;
            base += obj_len[i];
        end
        for (int e = 0; e < ENTRY_ROWS; e++) entry_word[e] = '0;
        entry_word[3] = 32'd1;  // 1016h sub 0
        entry_word[6] = 32'd4;  // 1018h sub 0
    endtask

    function automatic oda_rsp_t predict_access(oda_req_t rq);
        oda_rsp_t    rs;
        int          e;
        logic [31:0] keep;
        rs.status     = ST_NO_INDEX;
        rs.read_value = '0;
        for (int i = 0; i < OBJECT_ROWS; i++) begin
            if (obj_index_tab[i] == rq.object_index) begin
                e = obj_base[i] + int'(rq.sub_index);
                if (int'(rq.sub_index) >= obj_len[i] || e >= ENTRY_ROWS) begin
                    rs.status = ST_NO_SUB;
                end else if ((entry_acc[e] == ACC_WO && !rq.action) ||
                             ((entry_acc[e] == ACC_RO || entry_acc[e] == ACC_CONST) &&
                              rq.action)) begin
                    rs.status = ST_DENIED;
                end else if (entry_bytes[e] == 0 ||
                             entry_bytes[e] != int'(rq.byte_count)) begin
                    rs.status = ST_SIZE;
                end else begin
                    keep = (entry_bytes[e] >= 4) ? 32'hFFFF_FFFF :
                           ((32'd1 << (8 * entry_bytes[e])) - 32'd1);
                    rs.status = ST_OK;
                    if (rq.action) entry_word[e] = rq.write_value & keep;
                    else           rs.read_value = entry_word[e] & keep;
                end
            end
        end
        return rs;
    endfunction

    task automatic add_request(input logic action, input logic [15:0] idx,
                               input logic [7:0] sub, input logic [4:0] cnt,
                               input logic [31:0] value);
        req_item_t it;
        it.req.action       = action;
        it.req.object_index = idx;
        it.req.sub_index    = sub;
        it.req.byte_count   = cnt;
        it.req.write_value  = value;
        // Every 4th block of 50 requests goes back to back.
        it.gap   = ((queued_count / 50) % 4 == 2) ? 0 : $urandom_range(0, 9);
        it.drain = (queued_count == 25 || queued_count == 400);
        pending_requests.push_back(it);
        queued_count++;
    endtask

    // Request driver.
    always @(negedge aclk) begin
        logic next_valid;
        next_valid = s_valid && !req_fire;
        if (aresetn && !next_valid && pending_requests.size() != 0) begin
            if (gap_left < 0) gap_left = pending_requests[0].gap;
            if (!(pending_requests[0].drain && expected_results.size() != 0)) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    s_request <= pending_requests[0].req;
                    next_valid = 1'b1;
                    void'(pending_requests.pop_front());
                    gap_left = -1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Result receiver.
    always @(negedge aclk) begin
        logic next_ready;
        next_ready = m_ready;
        if (aresetn) begin
            if (m_ready && rsp_fire) begin
                next_ready = 1'b0;
                if (rsp_count == 200 || rsp_count == 520) hold_left = 400;
                else if ((rsp_count / 50) % 4 == 1)      hold_left = 0;
                else                                      hold_left = $urandom_range(0, 9);
            end
            if (!next_ready) begin
                if (hold_left > 0) hold_left--;
                else               next_ready = 1'b1;
            end
        end
        m_ready <= next_ready;
    end

    // Monitor and checker.
    always @(posedge aclk) begin
        oda_rsp_t want;
        if (!aresetn) begin
            req_fire <= 1'b0;
            rsp_fire <= 1'b0;
        end else begin
            req_fire <= s_valid && s_ready;
            rsp_fire <= m_valid && m_ready;
            if (m_valid && m_ready) begin
                rsp_count++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result status %0d data %h", $time,
                             m_result.status, m_result.read_value);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result.status !== want.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 want.status, m_result.status);
                    end
                    if (m_result.read_value !== want.read_value) begin
                        mismatches++;
                        $display("%0t: read_value expected %h got %h", $time,
                                 want.read_value, m_result.read_value);
                    end
                end
            end
            if (s_valid && s_ready) expected_results.push_back(predict_access(s_request));
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int          pick;
        int          slot;
        int          e;
        logic [15:0] idx;
        logic [7:0]  sub;
        logic [4:0]  cnt;

        load_dictionary();

        add_request(1'b0, 16'h1000, 8'd0, 5'd4, 32'h0);           // ro read
        add_request(1'b0, 16'h1000, 8'd0, 5'd0, 32'h0);           // zero count
        add_request(1'b0, 16'h1000, 8'd0, 5'd31, 32'hFFFF_FFFF);  // oversize count
        add_request(1'b1, 16'h1000, 8'd0, 5'd4, 32'h1234_5678);   // write to ro
        add_request(1'b0, 16'h1008, 8'd0, 5'd16, 32'h0);          // string read
        add_request(1'b1, 16'h1008, 8'd0, 5'd16, 32'h0);          // string write
        add_request(1'b0, 16'h1016, 8'd0, 5'd1, 32'h0);
        add_request(1'b1, 16'h1016, 8'd1, 5'd4, 32'hFFFF_FFFF);
        add_request(1'b0, 16'h1016, 8'd1, 5'd4, 32'h0);
        add_request(1'b1, 16'h1017, 8'd0, 5'd2, 32'hDEAD_BEEF);   // narrow write
        add_request(1'b0, 16'h1017, 8'd0, 5'd2, 32'h0);
        add_request(1'b0, 16'h1F51, 8'd1, 5'd4, 32'h0);           // wo read
        add_request(1'b1, 16'h1F51, 8'd1, 5'd4, 32'hA5A5_5A5A);
        add_request(1'b1, 16'h1F51, 8'd0, 5'd1, 32'h0000_00FF);   // ro write
        add_request(1'b0, 16'h1F51, 8'd6, 5'd4, 32'h0);           // past entry count
        add_request(1'b0, 16'h1F51, 8'd255, 5'd4, 32'h0);
        add_request(1'b0, 16'hFFFF, 8'd0, 5'd4, 32'h0);           // unknown index
        add_request(1'b1, 16'h0000, 8'd255, 5'd31, 32'hFFFF_FFFF);
        add_request(1'b0, 16'h1018, 8'd0, 5'd1, 32'h0);
        add_request(1'b0, 16'h1018, 8'd4, 5'd4, 32'h0);
        add_request(1'b1, 16'h1F80, 8'd0, 5'd4, 32'h1234_5678);
        add_request(1'b0, 16'h1F80, 8'd0, 5'd4, 32'h0);
        add_request(1'b1, 16'h1F80, 8'd0, 5'd2, 32'h0);           // short write
        add_request(1'b0, 16'h1001, 8'd0, 5'd1, 32'h0);

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            pick = $urandom_range(0, 99);
            slot = $urandom_range(0, OBJECT_ROWS - 1);
            if (pick < 85) begin
                idx = obj_index_tab[slot];
                if ($urandom_range(0, 9) < 8) sub = 8'($urandom_range(0, obj_len[slot] - 1));
                else                          sub = 8'($urandom_range(0, 255));
                e = obj_base[slot] + int'(sub);
                if ($urandom_range(0, 9) < 8 && int'(sub) < obj_len[slot])
                    cnt = 5'(entry_bytes[e]);
                else
                    cnt = 5'($urandom_range(0, 31));
            end else begin
                idx = 16'($urandom);
                sub = 8'($urandom);
                cnt = 5'($urandom);
            end
            add_request(1'($urandom_range(0, 1)), idx, sub, cnt, $urandom);
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0) $display("tb: success");
        else                 $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/oda_pkg.sv
design/oda_cell.sv
design/oda_entry.sv
design/object_dictionary_access.sv
design/oda_checker.sv
tb/sv/testbench.sv
